/* rtl/mlpq_pkg.sv */
`timescale 1ns / 1ps

package mlpq_pkg;

    // Fixed field widths of the stream channels
    localparam int OP_W          = 2;
    localparam int LEVEL_W       = 8;
    localparam int IN_PAYLOAD_W  = 32;
    localparam int STATUS_W      = 3;
    localparam int OUT_PAYLOAD_W = 32;
    localparam int OUT_LEVEL_W   = 4;

    // level and payload, filled up to whole bytes
    localparam int S_TDATA_W = 40;
    // out_payload and out_level, filled up to whole bytes
    localparam int M_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ       = 2'd0,
        OP_DEQ_BEST  = 2'd1,
        OP_DEQ_LEVEL = 2'd2,
        OP_DEQ_MIN   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_ENQUEUED  = 3'd0,
        STS_DEQUEUED  = 3'd1,
        STS_EMPTY     = 3'd2,
        STS_BAD_LEVEL = 3'd3,
        STS_FULL      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ENQ_WR = 4'b0010,
        ST_DEQ_RD = 4'b0100,
        ST_DEQ_WR = 4'b1000
    } state_t;

endpackage

/* rtl/multilevel_priority_queue.sv */
`timescale 1ns / 1ps

// Multilevel priority queue: one FIFO per level, level 0 most urgent, all
// levels sharing one pool of linked entries with a free list.
// Input channel (s_*): one transfer per command. s_tuser carries the op
// (enqueue, dequeue best, dequeue from level, dequeue at or above level),
// s_tdata carries level and payload. Output channel (m_*): exactly one
// transfer per command, in order; m_tuser carries the status, m_tdata the
// dequeued payload and the level it came from (zero when nothing popped).
// Bad level, pool full and nothing to dequeue are answered straight from
// ST_IDLE; an enqueue passes through ST_ENQ_WR and a dequeue through
// ST_DEQ_RD and then ST_DEQ_WR. No new command is taken until the
// sequencer is back in ST_IDLE.
// The dequeue cost is the chain head RAM -> pool next/payload RAM -> write
// back, each RAM having a registered read.
// Results sit in one output register; a new command is taken while it is
// empty or being taken in the same cycle, so a stalled receiver holds the
// result and blocks at most one command behind it.
// Reset (aresetn low, synchronous) empties all levels and marks the whole
// pool free. No clearing pass: untouched pool entries are handed out in
// index order from a high-water mark, so the block is ready right after
// reset.
module multilevel_priority_queue import mlpq_pkg::*; #(
    parameter int LEVELS       = 16,
    parameter int POOL_ENTRIES = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] level, [39:8] payload
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] out_payload, [35:32] out_level
    output logic [STATUS_W-1:0]  m_tuser    // [2:0] status
);

    localparam int LW = $clog2(LEVELS);
    localparam int IW = $clog2(POOL_ENTRIES);
    localparam int CW = $clog2(POOL_ENTRIES + 1);
    localparam logic [IW-1:0]      LAST_IDX    = IW'(POOL_ENTRIES - 1);
    localparam logic [CW-1:0]      POOL_COUNT  = CW'(POOL_ENTRIES);
    localparam logic [LEVEL_W:0]   LEVEL_LIMIT = (LEVEL_W + 1)'(LEVELS);

    // Control state
    state_t            state_reg, state_next;
    logic [LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [IW-1:0]     free_head_reg, free_head_next;
    logic [CW-1:0]     free_count_reg, free_count_next;
    logic [CW-1:0]     fresh_reg, fresh_next;      // entries below this were handed out
    logic              m_tvalid_reg;

    // Per-command working registers
    logic [LW-1:0]           lvl_reg, lvl_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic                    enq_hit_reg, enq_hit_next;     // level already had entries
    logic                    fresh_hit_reg, fresh_hit_next; // free head never used before
    logic [IW-1:0]           head_idx_reg, head_idx_next;
    logic                    last_reg, last_next;           // popped entry was the only one

    // Result register
    status_t                  m_status_reg;
    logic [OUT_PAYLOAD_W-1:0] m_payload_reg;
    logic [OUT_LEVEL_W-1:0]   m_level_reg;

    logic                     res_load;
    status_t                  res_status;
    logic [OUT_PAYLOAD_W-1:0] res_payload;
    logic [OUT_LEVEL_W-1:0]   res_level;

    // Input fields
    op_t                     in_op;
    logic [LEVEL_W-1:0]      in_level;
    logic [IN_PAYLOAD_W-1:0] in_payload;
    logic                    in_level_ok;
    logic                    accept;

    // Level search
    logic [LEVELS-1:0] cand;
    logic              pick_found;
    logic [LW-1:0]     pick_lvl;
    logic [LW-1:0]     lvl_sel;

    // RAM ports
    logic                    head_we, tail_we, next_we, pay_we;
    logic [IW-1:0]           head_wdata, tail_wdata, next_wdata;
    logic [IW-1:0]           next_waddr, next_raddr;
    logic [IW-1:0]           head_rdata, tail_rdata, next_rdata;
    logic [PAYLOAD_BITS-1:0] pay_rdata;

    assign in_op       = op_t'(s_tuser);
    assign in_level    = s_tdata[LEVEL_W-1:0];
    assign in_payload  = s_tdata[LEVEL_W +: IN_PAYLOAD_W];
    assign in_level_ok = {1'b0, in_level} < LEVEL_LIMIT;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Find the first nonempty level that the dequeue op allows
    always_comb begin
        cand = '0;
        for (int i = 0; i < LEVELS; i++) begin
            case (in_op)
                OP_DEQ_BEST:  cand[i] = nonempty_reg[i];
                OP_DEQ_LEVEL: cand[i] = nonempty_reg[i] && ((LEVEL_W + 1)'(i) == {1'b0, in_level});
                OP_DEQ_MIN:   cand[i] = nonempty_reg[i] && ((LEVEL_W + 1)'(i) >= {1'b0, in_level});
                default:      cand[i] = 1'b0;
            endcase
        end
    end

    always_comb begin
        pick_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                pick_lvl = LW'(i);
            end
        end
    end

    assign pick_found = |cand;
    assign lvl_sel    = (in_op == OP_ENQ) ? LW'(in_level) : pick_lvl;

    // Memories: level head and tail pointers, pool next pointers and payloads
    assign next_raddr = (state_reg == ST_DEQ_RD) ? head_rdata : free_head_reg;

    mlpq_ram #(.WIDTH(IW), .DEPTH(LEVELS)) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (lvl_reg),
        .wdata (head_wdata),
        .raddr (lvl_sel),
        .rdata (head_rdata)
    );

    mlpq_ram #(.WIDTH(IW), .DEPTH(LEVELS)) u_tail_ram (
        .aclk  (aclk),
        .we    (tail_we),
        .waddr (lvl_reg),
        .wdata (tail_wdata),
        .raddr (lvl_sel),
        .rdata (tail_rdata)
    );

    mlpq_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    mlpq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(POOL_ENTRIES)) u_payload_ram (
        .aclk  (aclk),
        .we    (pay_we),
        .waddr (free_head_reg),
        .wdata (payload_reg),
        .raddr (head_rdata),
        .rdata (pay_rdata)
    );

    // Command sequencer
    always_comb begin
        state_next      = state_reg;
        nonempty_next   = nonempty_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        lvl_next        = lvl_reg;
        payload_next    = payload_reg;
        enq_hit_next    = enq_hit_reg;
        fresh_hit_next  = fresh_hit_reg;
        head_idx_next   = head_idx_reg;
        last_next       = last_reg;

        head_we    = 1'b0;
        head_wdata = free_head_reg;
        tail_we    = 1'b0;
        tail_wdata = free_head_reg;
        next_we    = 1'b0;
        next_waddr = head_idx_reg;
        next_wdata = free_head_reg;
        pay_we     = 1'b0;

        res_load    = 1'b0;
        res_status  = STS_EMPTY;
        res_payload = '0;
        res_level   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_ENQ: begin
                            if (!in_level_ok) begin
                                res_load   = 1'b1;
                                res_status = STS_BAD_LEVEL;
                            end else if (free_count_reg == '0) begin
                                res_load   = 1'b1;
                                res_status = STS_FULL;
                            end else begin
                                // tail and free-head next pointer are being read
                                state_next     = ST_ENQ_WR;
                                lvl_next       = LW'(in_level);
                                payload_next   = PAYLOAD_BITS'(in_payload);
                                enq_hit_next   = nonempty_reg[LW'(in_level)];
                                fresh_hit_next = (CW'(free_head_reg) == fresh_reg);
                            end
                        end
                        OP_DEQ_BEST, OP_DEQ_LEVEL, OP_DEQ_MIN: begin
                            if (pick_found) begin
                                // head and tail of the chosen level are being read
                                state_next = ST_DEQ_RD;
                                lvl_next   = pick_lvl;
                            end else begin
                                res_load   = 1'b1;
                                res_status = STS_EMPTY;
                            end
                        end
                        default: begin
                            res_load   = 1'b1;
                            res_status = STS_EMPTY;
                        end
                    endcase
                end
            end

            ST_ENQ_WR: begin
                // Store the payload at the free head and link it behind the tail
                pay_we  = 1'b1;
                tail_we = 1'b1;
                if (enq_hit_reg) begin
                    next_we    = 1'b1;
                    next_waddr = tail_rdata;
                end else begin
                    head_we               = 1'b1;
                    nonempty_next[lvl_reg] = 1'b1;
                end
                // An entry never handed out still chains to its successor
                if (fresh_hit_reg) begin
                    free_head_next = (free_head_reg == LAST_IDX) ? '0
                                                                 : free_head_reg + IW'(1);
                    fresh_next     = fresh_reg + CW'(1);
                end else begin
                    free_head_next = next_rdata;
                end
                free_count_next = free_count_reg - CW'(1);
                res_load        = 1'b1;
                res_status      = STS_ENQUEUED;
                state_next      = ST_IDLE;
            end

            ST_DEQ_RD: begin
                // Head pointer is here; fetch its next pointer and payload
                head_idx_next = head_rdata;
                last_next     = (head_rdata == tail_rdata);
                state_next    = ST_DEQ_WR;
            end

            ST_DEQ_WR: begin
                if (last_reg) begin
                    nonempty_next[lvl_reg] = 1'b0;
                end else begin
                    head_we    = 1'b1;
                    head_wdata = next_rdata;
                end
                // Push the popped entry onto the front of the free list
                next_we        = 1'b1;
                next_waddr     = head_idx_reg;
                next_wdata     = free_head_reg;
                free_head_next = head_idx_reg;
                if (free_count_reg < POOL_COUNT) begin
                    free_count_next = free_count_reg + CW'(1);
                end
                res_load    = 1'b1;
                res_status  = STS_DEQUEUED;
                res_payload = OUT_PAYLOAD_W'(pay_rdata);
                res_level   = OUT_LEVEL_W'(lvl_reg);
                state_next  = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            nonempty_reg   <= '0;
            free_head_reg  <= '0;
            free_count_reg <= POOL_COUNT;
            fresh_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            nonempty_reg   <= nonempty_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg       <= lvl_next;
        payload_reg   <= payload_next;
        enq_hit_reg   <= enq_hit_next;
        fresh_hit_reg <= fresh_hit_next;
        head_idx_reg  <= head_idx_next;
        last_reg      <= last_next;
    end

    // Output register: load a new result, else drop the one taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_status_reg  <= res_status;
            m_payload_reg <= res_payload;
            m_level_reg   <= res_level;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_PAYLOAD_W - OUT_LEVEL_W){1'b0}},
                       m_level_reg, m_payload_reg};

`ifndef NO_ASSERTIONS
    // A multi-cycle command finishes into an empty output register
    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENQ_WR || state_reg == ST_DEQ_WR) |-> !m_tvalid_reg)
        else $error("result register busy at command completion");

    a_free_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= POOL_COUNT)
        else $error("free count above pool size");

    // Entries in use were all handed out below the high-water mark
    a_fresh_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (POOL_COUNT - free_count_reg) <= fresh_reg)
        else $error("more entries in use than ever handed out");

    a_nonempty_uses_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (|nonempty_reg) |-> (free_count_reg != POOL_COUNT))
        else $error("nonempty level with the whole pool free");

    a_deq_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEQ_WR) |-> $past(state_reg) == ST_DEQ_RD)
        else $error("dequeue write-back without pointer read");
`endif

endmodule

/* rtl/mlpq_ram.sv */
`timescale 1ns / 1ps

module mlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; a read of the address being
    // written returns the old word.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
